[hw/rtl/usb_transfer_descriptor_builder_assert.svh]
// Assertion macros for the checker file of the descriptor builder.
// Each macro checks on the rising edge of clock and is quiet while reset is high.
`ifndef USB_TRANSFER_DESCRIPTOR_BUILDER_ASSERT_SVH
`define USB_TRANSFER_DESCRIPTOR_BUILDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define USBTD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define USBTD_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/usbtd_pkg.sv]
`timescale 1ns / 1ps
package usbtd_pkg;

   // Default sizing of the descriptor chain.
   localparam int MAX_TDS_DEFAULT  = 64;
   localparam int TD_BYTES_DEFAULT = 16;

   // Transfer kinds.
   localparam logic [1:0] ACT_CTRL_IN  = 2'd0;
   localparam logic [1:0] ACT_CTRL_OUT = 2'd1;
   localparam logic [1:0] ACT_BULK_IN  = 2'd2;
   localparam logic [1:0] ACT_BULK_OUT = 2'd3;

   // Result error codes.
   localparam logic [1:0] ERR_NONE      = 2'd0;
   localparam logic [1:0] ERR_ZERO_SIZE = 2'd1;
   localparam logic [1:0] ERR_TOO_LONG  = 2'd2;

   // Packet identifiers.
   localparam logic [7:0] PID_SETUP = 8'h2D;
   localparam logic [7:0] PID_IN    = 8'h69;
   localparam logic [7:0] PID_OUT   = 8'hE1;

   // Descriptor word constants.
   localparam logic [31:0] LINK_TERMINATE   = 32'h0000_0001;
   localparam logic [31:0] STATUS_ACTIVE    = 32'h0080_0000;
   localparam logic [31:0] STATUS_LOW_SPEED = 32'h0400_0000;
   localparam logic [10:0] MAXLEN_ZERO      = 11'h7FF;
   localparam logic [10:0] MAXLEN_SETUP     = 11'd7;

   typedef struct packed {
      logic [1:0]  action;
      logic [6:0]  device_address;
      logic [3:0]  endpoint_number;
      logic        low_speed;
      logic [9:0]  max_packet;
      logic [15:0] transfer_length;
      logic [31:0] buffer_base;
      logic [31:0] setup_address;
      logic [31:0] chain_base;
   } req_type;

   typedef struct packed {
      logic [31:0] link_word;
      logic [31:0] status_word;
      logic [31:0] token_word;
      logic [31:0] buffer_word;
      logic [5:0]  slot_index;
      logic [1:0]  error_code;
      logic        last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SETUP,
      ST_DATA,
      ST_STATUS
   } state_type;

   typedef enum logic [2:0] {
      EMIT_ERR_ZERO,
      EMIT_ERR_LONG,
      EMIT_SETUP,
      EMIT_DATA,
      EMIT_STATUS
   } emit_kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic          capture;
      logic          emit;
      emit_kind_type kind;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic err_zero;
      logic err_long;
      logic is_control;
      logic is_ctrl_in;
      logic bulk_empty;
      logic data_more;
      logic data_last;
   } dp_status_type;

   // Assemble a token word: max length, data toggle, endpoint, address, PID.
   function automatic logic [31:0] make_token(input logic [10:0] maxlen,
                                              input logic        toggle,
                                              input logic [3:0]  ep,
                                              input logic [6:0]  addr,
                                              input logic [7:0]  pid);
      return {maxlen, 1'b0, toggle, ep, addr, pid};
   endfunction

endpackage

[hw/rtl/usbtd_controller.sv]
`timescale 1ns / 1ps
module usbtd_controller
   import usbtd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The output register can take a new descriptor when empty or being drained.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.err_zero || status.err_long) begin
               if (out_free) begin
                  state_in = ST_IDLE;
               end
            end else if (status.bulk_empty) begin
               state_in = ST_IDLE;
            end else if (status.is_control) begin
               state_in = ST_SETUP;
            end else begin
               state_in = ST_DATA;
            end
         end
         ST_SETUP: begin
            if (out_free) begin
               state_in = (status.is_ctrl_in && status.data_more) ? ST_DATA : ST_STATUS;
            end
         end
         ST_DATA: begin
            if (out_free && status.data_last) begin
               state_in = status.is_control ? ST_STATUS : ST_IDLE;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd.capture = (state_ff == ST_IDLE) && req_valid;
      cmd.emit    = 1'b0;
      cmd.kind    = EMIT_SETUP;
      case (state_ff)
         ST_CHECK: begin
            cmd.emit = out_free && (status.err_zero || status.err_long);
            cmd.kind = status.err_zero ? EMIT_ERR_ZERO : EMIT_ERR_LONG;
         end
         ST_SETUP: begin
            cmd.emit = out_free;
            cmd.kind = EMIT_SETUP;
         end
         ST_DATA: begin
            cmd.emit = out_free;
            cmd.kind = EMIT_DATA;
         end
         ST_STATUS: begin
            cmd.emit = out_free;
            cmd.kind = EMIT_STATUS;
         end
         default: begin
            cmd.emit = 1'b0;
         end
      endcase
   end

   // Output valid follows loads and drains of the result register.
   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[hw/rtl/usbtd_datapath.sv]
`timescale 1ns / 1ps
module usbtd_datapath
   import usbtd_pkg::*;
#(
   parameter int MAX_TDS  = MAX_TDS_DEFAULT,
   parameter int TD_BYTES = TD_BYTES_DEFAULT
) (
   input  logic          clock,
   input  req_type       req_data,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output rsp_type       rsp_data
);

   localparam int LimW  = $clog2(MAX_TDS + 1);
   localparam int ProdW = LimW + 10;
   localparam int CmpW  = (ProdW > 16) ? ProdW : 16;
   localparam logic [LimW-1:0]  LimitCtrl = LimW'(MAX_TDS - 2);
   localparam logic [LimW-1:0]  LimitBulk = LimW'(MAX_TDS);
   localparam logic [31:0]      TdStep    = 32'(TD_BYTES);

   req_type     req_ff;
   logic [15:0] remain_ff, remain_in;
   logic [31:0] buf_ff, buf_in;
   logic [31:0] link_next_ff, link_next_in;
   logic [5:0]  slot_ff, slot_in;
   logic        odd_ff, odd_in;
   rsp_type     rsp_ff, rsp_in;

   logic            is_control, is_ctrl_in;
   logic [LimW-1:0] limit;
   logic [ProdW-1:0] capacity;
   logic [9:0]      pkt_size;
   logic [10:0]     pkt_maxlen;
   logic            pkt_last;
   logic [7:0]      data_pid;
   logic            data_toggle;
   logic [3:0]      data_ep;
   logic [31:0]     status_word;

   assign is_control = !req_ff.action[1];
   assign is_ctrl_in = (req_ff.action == ACT_CTRL_IN);

   // Largest data length that still fits the chain: limit packets of max size.
   assign limit    = is_ctrl_in ? LimitCtrl : LimitBulk;
   assign capacity = ProdW'(req_ff.max_packet) * ProdW'(limit);

   // Size of the current data packet and whether it finishes the data stage.
   assign pkt_last   = remain_ff <= {6'd0, req_ff.max_packet};
   assign pkt_size   = pkt_last ? remain_ff[9:0] : req_ff.max_packet;
   assign pkt_maxlen = {1'b0, pkt_size} - 11'd1;

   assign data_pid    = (req_ff.action == ACT_BULK_OUT) ? PID_OUT : PID_IN;
   assign data_toggle = is_control ? !odd_ff : odd_ff;
   assign data_ep     = is_control ? 4'd0 : req_ff.endpoint_number;
   assign status_word = STATUS_ACTIVE | (req_ff.low_speed ? STATUS_LOW_SPEED : 32'd0);

   // Status toward the controller.
   always_comb begin
      status.err_zero   = (req_ff.max_packet == 10'd0);
      status.err_long   = !status.err_zero && (req_ff.action != ACT_CTRL_OUT) &&
                          (CmpW'(req_ff.transfer_length) > CmpW'(capacity));
      status.is_control = is_control;
      status.is_ctrl_in = is_ctrl_in;
      status.bulk_empty = !is_control && (req_ff.transfer_length == 16'd0);
      status.data_more  = (remain_ff != 16'd0);
      status.data_last  = pkt_last;
   end

   // Descriptor assembly for the kind the controller asks for.
   always_comb begin
      rsp_in             = rsp_ff;
      rsp_in.link_word   = link_next_ff;
      rsp_in.status_word = status_word;
      rsp_in.slot_index  = slot_ff;
      rsp_in.error_code  = ERR_NONE;
      rsp_in.last        = 1'b0;
      case (cmd.kind)
         EMIT_ERR_ZERO, EMIT_ERR_LONG: begin
            rsp_in.link_word   = 32'd0;
            rsp_in.status_word = 32'd0;
            rsp_in.token_word  = 32'd0;
            rsp_in.buffer_word = 32'd0;
            rsp_in.slot_index  = 6'd0;
            rsp_in.error_code  = (cmd.kind == EMIT_ERR_ZERO) ? ERR_ZERO_SIZE : ERR_TOO_LONG;
            rsp_in.last        = 1'b1;
         end
         EMIT_SETUP: begin
            rsp_in.token_word  = make_token(MAXLEN_SETUP, 1'b0, 4'd0,
                                            req_ff.device_address, PID_SETUP);
            rsp_in.buffer_word = req_ff.setup_address;
         end
         EMIT_DATA: begin
            rsp_in.token_word  = make_token(pkt_maxlen, data_toggle, data_ep,
                                            req_ff.device_address, data_pid);
            rsp_in.buffer_word = buf_ff;
            if (!is_control && pkt_last) begin
               rsp_in.link_word = LINK_TERMINATE;
               rsp_in.last      = 1'b1;
            end
         end
         EMIT_STATUS: begin
            rsp_in.link_word   = LINK_TERMINATE;
            rsp_in.token_word  = make_token(MAXLEN_ZERO, 1'b1, 4'd0, req_ff.device_address,
                                            is_ctrl_in ? PID_OUT : PID_IN);
            rsp_in.buffer_word = 32'd0;
            rsp_in.last        = 1'b1;
         end
         default: begin
            rsp_in.last = 1'b1;
         end
      endcase
   end

   // Chain walk: link, slot, remaining bytes, buffer pointer and toggle.
   always_comb begin
      remain_in    = remain_ff;
      buf_in       = buf_ff;
      link_next_in = link_next_ff;
      slot_in      = slot_ff;
      odd_in       = odd_ff;
      if (cmd.capture) begin
         remain_in    = req_data.transfer_length;
         buf_in       = req_data.buffer_base;
         link_next_in = req_data.chain_base + TdStep;
         slot_in      = 6'd0;
         odd_in       = 1'b0;
      end else if (cmd.emit) begin
         link_next_in = link_next_ff + TdStep;
         slot_in      = slot_ff + 6'd1;
         if (cmd.kind == EMIT_DATA) begin
            remain_in = remain_ff - {6'd0, pkt_size};
            buf_in    = buf_ff + {22'd0, req_ff.max_packet};
            odd_in    = !odd_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
      remain_ff    <= remain_in;
      buf_ff       <= buf_in;
      link_next_ff <= link_next_in;
      slot_ff      <= slot_in;
      odd_ff       <= odd_in;
   end

   assign rsp_data = rsp_ff;

endmodule

[hw/rtl/usb_transfer_descriptor_builder.sv]
`timescale 1ns / 1ps
// Builds the UHCI transfer descriptor chain for one transfer request at a time. Each request
// transaction yields one descriptor transaction per chain entry (link, status, token and buffer
// words plus slot index), the last one flagged; a zero packet size or a chain longer than
// MAX_TDS yields a single flagged error transaction instead, and a zero-length bulk request
// yields none. A good request is taken in the idle state, its size is checked against the
// chain limit with a single multiply in the check state, and then one descriptor per cycle
// goes through the output register, which holds on result stall. The result of an error
// request is loaded in the check state, and an empty bulk request leaves the check state with
// none. A new request is taken as soon as the last descriptor has entered the output register.
module usb_transfer_descriptor_builder
   import usbtd_pkg::*;
#(
   parameter int MAX_TDS  = MAX_TDS_DEFAULT,
   parameter int TD_BYTES = TD_BYTES_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Sequencing of request check and descriptor emission.
   usbtd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Request registers, chain counters and descriptor assembly.
   usbtd_datapath #(
      .MAX_TDS  (MAX_TDS),
      .TD_BYTES (TD_BYTES)
   ) u_datapath (
      .clock    (clock),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

[hw/rtl/usbtd_checker.sv]
`timescale 1ns / 1ps
`include "usb_transfer_descriptor_builder_assert.svh"
module usbtd_checker
   import usbtd_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   logic req_take;
   logic rsp_held;
   logic rsp_is_error;
   logic rsp_err_clean;
   logic rsp_good_last;

   // Port conditions that the checks below refer to.
   assign req_take      = req_valid && !req_stall;
   assign rsp_held      = rsp_valid && rsp_stall;
   assign rsp_is_error  = rsp_valid && (rsp_data.error_code != ERR_NONE);
   assign rsp_err_clean = rsp_data.last && (rsp_data.link_word == 32'd0) &&
                          (rsp_data.token_word == 32'd0);
   assign rsp_good_last = rsp_valid && rsp_data.last && (rsp_data.error_code == ERR_NONE);

   // A stalled descriptor stays offered unchanged.
   `USBTD_ASSERT_NXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp_data), "stalled result changed")

   // The block is busy in the cycle after it takes a request.
   `USBTD_ASSERT_NXT(a_busy_after_req, req_take, req_stall, "request taken without going busy")

   // An error result ends its request, and its link and token words are zero.
   `USBTD_ASSERT_IMP(a_error_shape, rsp_is_error, rsp_err_clean, "malformed error result")

   // The final descriptor of a good chain terminates the link list.
   `USBTD_ASSERT_IMP(a_last_terminates, rsp_good_last, rsp_data.link_word == LINK_TERMINATE, "no terminate")

endmodule

bind usb_transfer_descriptor_builder usbtd_checker u_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
   import usbtd_pkg::*;

   localparam int CYCLE_LIMIT   = 400_000;
   localparam int DRAIN_CYCLES  = 80;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_ITEMS  = 160;
   localparam int PHASE_ITEMS   = 40;
   localparam int DIRECTED_ROWS = 20;

   // How the expected outcome of a directed row is given.
   typedef enum logic [1:0] {
      ROW_PREDICT,
      ROW_NO_TD,
      ROW_ERROR
   } row_kind_type;

   typedef struct packed {
      req_type      req;
      row_kind_type kind;
      logic [1:0]   err;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic    pressure_go = 1'b0;
   logic    hold_off = 1'b0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      cycle_count = 0;
   int      mismatches = 0;
   int      n_requests = 0;
   int      n_tds = 0;
   int      n_error_tds = 0;

   // Descriptors still owed by the block, oldest first.
   rsp_type expected_tds[$];

   usb_transfer_descriptor_builder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #2 clock = ~clock;

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Safety net against a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Appends one descriptor to the end of the expected list.
   function automatic void queue_td(input rsp_type td);
      expected_tds = {expected_tds, td};
   endfunction

   function automatic req_type mk_req(input logic [1:0] action, input logic [6:0] addr,
                                      input logic [3:0] ep, input logic ls,
                                      input logic [9:0] mp, input logic [15:0] len,
                                      input logic [31:0] bufb, input logic [31:0] setup,
                                      input logic [31:0] chain);
      req_type r;
      r.action          = action;
      r.device_address  = addr;
      r.endpoint_number = ep;
      r.low_speed       = ls;
      r.max_packet      = mp;
      r.transfer_length = len;
      r.buffer_base     = bufb;
      r.setup_address   = setup;
      r.chain_base      = chain;
      return r;
   endfunction

   // Works out the descriptor chain that one transfer request yields and queues it.
   task automatic build_td_chain(input req_type r);
      logic [31:0] mp;
      logic [31:0] len;
      logic [31:0] n_data;
      logic [31:0] count;
      logic [31:0] d;
      logic [31:0] remain;
      logic [31:0] size;
      logic [31:0] status;
      logic [10:0] maxlen;
      logic        toggle;
      logic [3:0]  ep;
      logic [7:0]  pid;
      logic        ctrl;
      rsp_type     td;
      mp     = {22'd0, r.max_packet};
      len    = {16'd0, r.transfer_length};
      ctrl   = (r.action == ACT_CTRL_IN) || (r.action == ACT_CTRL_OUT);
      status = STATUS_ACTIVE | (r.low_speed ? STATUS_LOW_SPEED : 32'd0);
      td     = '0;
      td.last = 1'b1;
      if (mp == 0) begin
         td.error_code = ERR_ZERO_SIZE;
         queue_td(td);
         return;
      end
      n_data = (len + mp - 1) / mp;
      case (r.action)
         ACT_CTRL_OUT: count = 2;
         ACT_CTRL_IN:  count = n_data + 2;
         default:      count = n_data;
      endcase
      if (count > MAX_TDS_DEFAULT) begin
         td.error_code = ERR_TOO_LONG;
         queue_td(td);
         return;
      end
      for (logic [31:0] k = 0; k < count; k++) begin
         td.last        = (k + 1 == count);
         td.link_word   = td.last ? LINK_TERMINATE : r.chain_base + (k + 1) * TD_BYTES_DEFAULT;
         td.status_word = status;
         td.slot_index  = k[5:0];
         td.error_code  = ERR_NONE;
         if (ctrl && k == 0) begin
            // Setup stage always moves the eight setup bytes on endpoint zero.
            td.token_word  = {MAXLEN_SETUP, 1'b0, 1'b0, 4'd0, r.device_address, PID_SETUP};
            td.buffer_word = r.setup_address;
         end else if (ctrl && td.last) begin
            // Status stage is zero length, DATA1, opposite direction to the data stage.
            pid = (r.action == ACT_CTRL_IN) ? PID_OUT : PID_IN;
            td.token_word  = {MAXLEN_ZERO, 1'b0, 1'b1, 4'd0, r.device_address, pid};
            td.buffer_word = 32'd0;
         end else begin
            // Data packet: control data starts at DATA1, bulk at DATA0.
            d      = ctrl ? k - 1 : k;
            remain = len - d * mp;
            size   = (remain < mp) ? remain : mp;
            maxlen = size[10:0] - 11'd1;
            toggle = ctrl ? ~d[0] : d[0];
            ep     = ctrl ? 4'd0 : r.endpoint_number;
            pid    = (r.action == ACT_BULK_OUT) ? PID_OUT : PID_IN;
            td.token_word  = {maxlen, 1'b0, toggle, ep, r.device_address, pid};
            td.buffer_word = r.buffer_base + d * mp;
         end
         queue_td(td);
      end
   endtask

   // Directed requests: zero packet size for every kind, empty bulk, chain limit edges,
   // field extremes, address wrap and a short last packet.
   function automatic directed_row_type directed_row(input int i);
      directed_row_type row;
      row.kind = ROW_PREDICT;
      row.err  = ERR_NONE;
      case (i)
         0: row = '{mk_req(ACT_CTRL_IN, 7'd0, 4'd0, 1'b0, 10'd0, 16'd0, 32'd0, 32'd0, 32'd0),
                    ROW_ERROR, ERR_ZERO_SIZE};
         1: row = '{mk_req(ACT_BULK_OUT, 7'h7F, 4'hF, 1'b1, 10'd0, 16'hFFFF, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF), ROW_ERROR, ERR_ZERO_SIZE};
         2: row = '{mk_req(ACT_CTRL_OUT, 7'd5, 4'd3, 1'b0, 10'd0, 16'd8, 32'h1000, 32'h2000,
                           32'h3000), ROW_ERROR, ERR_ZERO_SIZE};
         3: row = '{mk_req(ACT_BULK_IN, 7'd9, 4'd1, 1'b1, 10'd0, 16'd64, 32'h10, 32'h20,
                           32'h30), ROW_ERROR, ERR_ZERO_SIZE};
         4: row = '{mk_req(ACT_BULK_IN, 7'd3, 4'd2, 1'b0, 10'd64, 16'd0, 32'h4000, 32'h0,
                           32'h5000), ROW_NO_TD, ERR_NONE};
         5: row = '{mk_req(ACT_BULK_OUT, 7'h7F, 4'hF, 1'b1, 10'h3FF, 16'd0, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF), ROW_NO_TD, ERR_NONE};
         6: row = '{mk_req(ACT_BULK_IN, 7'd1, 4'd1, 1'b0, 10'd1, 16'd65, 32'h100, 32'h0,
                           32'h200), ROW_ERROR, ERR_TOO_LONG};
         7: row = '{mk_req(ACT_CTRL_IN, 7'd2, 4'd0, 1'b0, 10'd1, 16'd63, 32'h100, 32'h80,
                           32'h200), ROW_ERROR, ERR_TOO_LONG};
         8: row = '{mk_req(ACT_CTRL_IN, 7'd2, 4'd7, 1'b1, 10'd1, 16'd62, 32'h100, 32'h80,
                           32'h200), ROW_PREDICT, ERR_NONE};
         9: row = '{mk_req(ACT_BULK_OUT, 7'd4, 4'd9, 1'b0, 10'd1, 16'd64, 32'hFFFF_FFE0,
                           32'h0, 32'hFFFF_FF00), ROW_PREDICT, ERR_NONE};
         10: row = '{mk_req(ACT_CTRL_OUT, 7'h7F, 4'hF, 1'b1, 10'd1, 16'hFFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF, 32'hFFFF_FFF0), ROW_PREDICT, ERR_NONE};
         11: row = '{mk_req(ACT_CTRL_IN, 7'd10, 4'd0, 1'b0, 10'd8, 16'd0, 32'h0, 32'h600,
                            32'h700), ROW_PREDICT, ERR_NONE};
         12: row = '{mk_req(ACT_CTRL_IN, 7'd11, 4'd0, 1'b1, 10'h3FF, 16'd1000, 32'h8000,
                            32'h9000, 32'hA000), ROW_PREDICT, ERR_NONE};
         13: row = '{mk_req(ACT_CTRL_IN, 7'd12, 4'd5, 1'b0, 10'h3FF, 16'd2046, 32'hFFFF_FC00,
                            32'h40, 32'hFFFF_FFE0), ROW_PREDICT, ERR_NONE};
         14: row = '{mk_req(ACT_BULK_IN, 7'd13, 4'd6, 1'b0, 10'h3FF, 16'hFFFF, 32'h0, 32'h0,
                            32'h0), ROW_ERROR, ERR_TOO_LONG};
         15: row = '{mk_req(ACT_BULK_OUT, 7'd14, 4'hF, 1'b1, 10'h3FF, 16'd65472, 32'h1234_5678,
                            32'h0, 32'h8765_4320), ROW_PREDICT, ERR_NONE};
         16: row = '{mk_req(ACT_BULK_IN, 7'h7F, 4'hF, 1'b0, 10'h3FF, 16'd1, 32'hDEAD_BEE0,
                            32'h0, 32'h10), ROW_PREDICT, ERR_NONE};
         17: row = '{mk_req(ACT_CTRL_IN, 7'h7F, 4'hF, 1'b1, 10'h3FF, 16'hFFFF, 32'h0, 32'h0,
                            32'h0), ROW_ERROR, ERR_TOO_LONG};
         18: row = '{mk_req(ACT_BULK_OUT, 7'd21, 4'd8, 1'b0, 10'd8, 16'd20, 32'h2000, 32'h0,
                            32'h3000), ROW_PREDICT, ERR_NONE};
         default: row = '{mk_req(ACT_CTRL_IN, 7'd0, 4'd0, 1'b0, 10'd1, 16'd0, 32'd0, 32'd0,
                                 32'd0), ROW_PREDICT, ERR_NONE};
      endcase
      return row;
   endfunction

   // Random requests: mostly short chains, some near the chain limit, some errors.
   function automatic req_type random_request();
      req_type r;
      int      roll;
      int      n_pkt;
      int      mp;
      int      len;
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         mp  = 0;
         len = $urandom_range(0, 65535);
      end else if (roll < 15) begin
         n_pkt = 62 + $urandom_range(0, 3);
         mp    = $urandom_range(1, 1008);
         len   = n_pkt * mp - $urandom_range(0, mp - 1);
      end else if (roll < 25) begin
         mp  = $urandom_range(1, 1023);
         len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535);
      end else begin
         mp    = $urandom_range(1, 1023);
         n_pkt = $urandom_range(0, 12);
         len   = (n_pkt == 0) ? 0 : n_pkt * mp - $urandom_range(0, mp - 1);
      end
      r.action          = 2'($urandom_range(0, 3));
      r.device_address  = 7'($urandom_range(0, 127));
      r.endpoint_number = 4'($urandom_range(0, 15));
      r.low_speed       = 1'($urandom_range(0, 1));
      r.max_packet      = mp[9:0];
      r.transfer_length = len[15:0];
      r.buffer_base     = $urandom;
      r.setup_address   = $urandom;
      r.chain_base      = $urandom;
      return r;
   endfunction

   // Offers one request transaction, after a random gap, and queues its descriptors.
   task automatic send_request(input req_type r, input directed_row_type row, input bit typed);
      rsp_type err_td;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n_requests++;
      if (typed && row.kind == ROW_ERROR) begin
         err_td            = '0;
         err_td.error_code = row.err;
         err_td.last       = 1'b1;
         queue_td(err_td);
      end else if (!(typed && row.kind == ROW_NO_TD)) begin
         build_td_chain(r);
      end
   endtask

   // Long receiver hold-off so the block backs up into its request channel.
   initial begin
      wait (pressure_go);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Request side: directed table, then random requests across the idling phases.
   initial begin
      directed_row_type row;
      while (reset) @(posedge clock);
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_row(i);
         send_request(row.req, row, 1'b1);
      end
      pressure_go <= 1'b1;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         case (i / PHASE_ITEMS)
            0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct <= 81; recv_stall_pct <= 0;  end
            2: begin send_idle_pct <= 0;  recv_stall_pct <= 81; end
            default: begin send_idle_pct <= 10; recv_stall_pct <= 10; end
         endcase
         send_request(random_request(), '0, 1'b0);
      end
      req_valid <= 1'b0;

      // Drain, then give an empty bulk request or a stray descriptor time to show up.
      while (expected_tds.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d transfer requests; checked %0d descriptors, %0d of them errors.",
               n_requests, n_tds, n_error_tds);
      $display("Idling phases: none, sender gaps, receiver stalls, both, plus one long hold-off.");
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   task automatic check_word(input string name, input logic [31:0] want,
                             input logic [31:0] got);
      if (got !== want) begin
         $error("%s expected 0x%0h actual 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   // Descriptor side: random stall, and every accepted transaction is compared in order.
   always @(posedge clock) begin : td_check
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= hold_off || ($urandom_range(0, 99) < recv_stall_pct);
         if (rsp_valid && !rsp_stall) begin
            if (expected_tds.size() == 0) begin
               $error("descriptor transaction with nothing expected, slot %0d",
                      rsp_data.slot_index);
               mismatches++;
            end else begin
               want = expected_tds.pop_front();
               check_word("link_word", want.link_word, rsp_data.link_word);
               check_word("status_word", want.status_word, rsp_data.status_word);
               check_word("token_word", want.token_word, rsp_data.token_word);
               check_word("buffer_word", want.buffer_word, rsp_data.buffer_word);
               check_word("slot_index", {26'd0, want.slot_index}, {26'd0, rsp_data.slot_index});
               check_word("error_code", {30'd0, want.error_code}, {30'd0, rsp_data.error_code});
               check_word("last", {31'd0, want.last}, {31'd0, rsp_data.last});
               n_tds++;
               if (want.error_code != ERR_NONE) n_error_tds++;
            end
         end
      end
   end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/usbtd_pkg.sv
hw/rtl/usbtd_controller.sv
hw/rtl/usbtd_datapath.sv
hw/rtl/usb_transfer_descriptor_builder.sv
hw/rtl/usbtd_checker.sv
tb/tb.sv
